### hdl/mct_pkg.sv
// Package for the mouse cursor tracker: codes, defaults and shared types.
`default_nettype none
package mct_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int CLIP_HI_RESET      = 4095;
  localparam int CFG_IDX_BITS       = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd3;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  localparam int BTN_LEFT_BIT  = 0;
  localparam int BTN_RIGHT_BIT = 1;

  typedef struct packed {
    logic left_held;
    logic right_held;
    logic left_pressed;
    logic left_released;
    logic right_pressed;
    logic right_released;
  } btn_t;

endpackage
`default_nettype wire

### hdl/mouse_cursor_tracker_core.sv
// Mouse cursor tracker: packet or set-position item in, clamped cursor and buttons out.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: a mouse packet
//   (kind 0: status byte, signed dx, dy) or a set-position request (kind 1).
//   Output channel (out_valid_o / out_ready_i) returns exactly one result per
//   item: clamped cursor x/y, button levels and press/release edges.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes one clip box edge
//   at a time; index 0 left, 1 top, 2 right, 3 bottom, others ignored.
//   Result: registered; valid the cycle after the item is accepted unless an
//   earlier result still waits. Throughput: one item per cycle while ready is
//   high, set by the add-and-clamp loop from the position register back to itself.
//   Stall: an output register plus one skid entry; the block keeps taking
//   items while one result waits and drops ready only with both full.
//   Reset: position and button history clear to zero, clip box to 0..4095 (the
//   full range at 12-bit coordinates), both result entries empty.
`default_nettype none
module mouse_cursor_tracker_core
  import mct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]   cfg_data_i,

  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    kind_i,
  input  wire logic [7:0]              status_byte_i,
  input  wire logic signed [7:0]       delta_x_i,
  input  wire logic signed [7:0]       delta_y_i,
  input  wire logic [COORD_BITS-1:0]   set_x_i,
  input  wire logic [COORD_BITS-1:0]   set_y_i,

  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [COORD_BITS-1:0]        cursor_x_o,
  output logic [COORD_BITS-1:0]        cursor_y_o,
  output logic                         left_held_o,
  output logic                         right_held_o,
  output logic                         left_pressed_o,
  output logic                         left_released_o,
  output logic                         right_pressed_o,
  output logic                         right_released_o
);

  localparam int SW = COORD_BITS + 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    btn_t                  btn;
  } res_t;

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic signed [SW-1:0]   v,
    input logic [COORD_BITS-1:0]  lo,
    input logic [COORD_BITS-1:0]  hi
  );
    logic signed [SW-1:0] los;
    logic signed [SW-1:0] his;
    los = $signed({2'b00, lo});
    his = $signed({2'b00, hi});
    if (v < los) begin
      return lo;
    end else if (v > his) begin
      return hi;
    end
    return v[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic                  left_now_q, right_now_q, left_before_q, right_before_q;
  logic                  left_now_d, right_now_d, left_before_d, right_before_d;
  logic [COORD_BITS-1:0] pre_x, pre_y;
  logic signed [SW-1:0]  sum_x, sum_y;
  res_t                  res_d, out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;
  logic                  in_acc, out_take;

  // clip box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= COORD_BITS'(CLIP_HI_RESET);
      clip_bottom_q <= COORD_BITS'(CLIP_HI_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i;
        CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i;
        CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  always_comb begin
    // stored position is re-clamped against the current box first
    pre_x = clamp_axis($signed({2'b00, pos_x_q}), clip_left_q, clip_right_q);
    pre_y = clamp_axis($signed({2'b00, pos_y_q}), clip_top_q, clip_bottom_q);
    sum_x = $signed({2'b00, pre_x}) + SW'(delta_x_i);
    sum_y = $signed({2'b00, pre_y}) - SW'(delta_y_i);

    left_now_d     = left_now_q;
    right_now_d    = right_now_q;
    left_before_d  = left_before_q;
    right_before_d = right_before_q;
    if (kind_i == KIND_MOVE) begin
      left_before_d  = left_now_q;
      right_before_d = right_now_q;
      left_now_d     = status_byte_i[BTN_LEFT_BIT];
      right_now_d    = status_byte_i[BTN_RIGHT_BIT];
      pos_x_d        = clamp_axis(sum_x, clip_left_q, clip_right_q);
      pos_y_d        = clamp_axis(sum_y, clip_top_q, clip_bottom_q);
    end else begin
      pos_x_d = clamp_axis($signed({2'b00, set_x_i}), clip_left_q, clip_right_q);
      pos_y_d = clamp_axis($signed({2'b00, set_y_i}), clip_top_q, clip_bottom_q);
    end

    res_d.x                  = pos_x_d;
    res_d.y                  = pos_y_d;
    res_d.btn.left_held      = left_now_d;
    res_d.btn.right_held     = right_now_d;
    res_d.btn.left_pressed   = !left_before_d && left_now_d;
    res_d.btn.left_released  = left_before_d && !left_now_d;
    res_d.btn.right_pressed  = !right_before_d && right_now_d;
    res_d.btn.right_released = right_before_d && !right_now_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      left_now_q     <= 1'b0;
      right_now_q    <= 1'b0;
      left_before_q  <= 1'b0;
      right_before_q <= 1'b0;
    end else if (in_acc) begin
      pos_x_q        <= pos_x_d;
      pos_y_q        <= pos_y_d;
      left_now_q     <= left_now_d;
      right_now_q    <= right_now_d;
      left_before_q  <= left_before_d;
      right_before_q <= right_before_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc && (!out_valid_q || out_take)) begin
      out_q <= res_d;
    end
    if (in_acc && out_valid_q && !out_take) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_x_o       = out_q.x;
  assign cursor_y_o       = out_q.y;
  assign left_held_o      = out_q.btn.left_held;
  assign right_held_o     = out_q.btn.right_held;
  assign left_pressed_o   = out_q.btn.left_pressed;
  assign left_released_o  = out_q.btn.left_released;
  assign right_pressed_o  = out_q.btn.right_pressed;
  assign right_released_o = out_q.btn.right_released;

endmodule
`default_nettype wire
